// ===== sv/sgi_pkg.sv =====
package sgi_pkg;

	// Default coordinate width, signed Q16.8
	localparam int COORD_WIDTH_DEF = 24;

	// How the crossing is solved for one segment pair
	typedef enum logic [1:0] {
		MODE_NONE,   // degenerate, parallel or both vertical: no line crossing
		MODE_GEN,    // neither segment vertical
		MODE_BVERT,  // B vertical, A not
		MODE_AVERT   // A vertical, B not
	} mode_t;

endpackage

// ===== sv/sgi_pair_if.sv =====
interface sgi_pair_if import sgi_pkg::*; #(parameter int W = COORD_WIDTH_DEF);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] a_start_x;
	logic signed [W-1:0] a_start_y;
	logic signed [W-1:0] a_end_x;
	logic signed [W-1:0] a_end_y;
	logic signed [W-1:0] b_start_x;
	logic signed [W-1:0] b_start_y;
	logic signed [W-1:0] b_end_x;
	logic signed [W-1:0] b_end_y;

	modport source (
		output valid, a_start_x, a_start_y, a_end_x, a_end_y,
		output b_start_x, b_start_y, b_end_x, b_end_y,
		input  ready
	);
	modport sink (
		input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
		input  b_start_x, b_start_y, b_end_x, b_end_y,
		output ready
	);
endinterface

// ===== sv/sgi_result_if.sv =====
interface sgi_result_if import sgi_pkg::*; #(parameter int W = COORD_WIDTH_DEF);
	logic                valid;
	logic                ready;
	logic                hit;
	logic signed [W-1:0] cross_x;
	logic signed [W-1:0] cross_y;

	modport source (output valid, hit, cross_x, cross_y, input ready);
	modport sink (input valid, hit, cross_x, cross_y, output ready);
endinterface

// ===== sv/sgi_div_stage.sv =====
module sgi_div_stage import sgi_pkg::*; #(
	parameter int DW = 2 * COORD_WIDTH_DEF + 3,
	parameter int NW = 3 * COORD_WIDTH_DEF + 4
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] den,
	input  logic [DW-1:0] rem_i,
	input  logic [NW-1:0] nq_i,
	output logic [DW-1:0] rem_o,
	output logic [NW-1:0] nq_o
);

	logic [DW:0]   cand;
	logic [DW:0]   diff;
	logic          ge;
	logic [DW-1:0] rem_n;

	// one restoring step: bring down the next numerator bit, subtract if it fits
	always_comb begin
		cand  = {rem_i, nq_i[NW-1]};
		diff  = cand - {1'b0, den};
		ge    = (cand >= {1'b0, den});
		rem_n = ge ? diff[DW-1:0] : cand[DW-1:0];
	end

	// quotient bits shift in as numerator bits shift out
	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= rem_n;
			nq_o  <= {nq_i[NW-2:0], ge};
		end
	end

endmodule

// ===== sv/segment_intersection.sv =====
// Segment intersection, streaming.
// pairs   : one beat carries the two end points of segment A and of segment B,
//           signed Q16.8 at COORD_WIDTH bits.
// results : one beat per pair: hit, and the crossing point truncated toward
//           zero and saturated (zero when the lines do not meet in one point).
// Throughput: one pair per cycle; the block takes a new beat every cycle that
// the result side is not stalled.
// Pipeline: the accepting edge loads the first of six stages of differences, products,
// split wide products and divider operands, then come one stage per quotient bit of
// the two parallel restoring dividers (3*COORD_WIDTH + 4), and the output stage for
// rounding, saturation and span tests.
// Stall: when results.ready is low and a result is waiting, the whole pipeline
// holds and pairs.ready drops; nothing is lost or repeated.
// Reset: arst_n clears all valid bits; the data registers are not reset.
module segment_intersection import sgi_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	sgi_pair_if.sink     pairs,
	sgi_result_if.source results
);

	localparam int W   = COORD_WIDTH;
	localparam int PW  = 2 * W + 2;  // product of two differences
	localparam int DW  = 2 * W + 3;  // denominator and numerator of the line solve
	localparam int NW  = 3 * W + 4;  // divider numerator
	localparam int QS  = W + 4;      // clamped signed quotient
	localparam int LW  = W + 2;      // low slice of the solve numerator
	localparam int PPW = 2 * W + 4;  // partial product of a numerator slice

	localparam logic signed [QS:0] VHI = (QS+1)'((64'sd1 <<< (W - 1)) - 64'sd1);
	localparam logic signed [QS:0] VLO = -VHI - (QS+1)'(1);

	typedef struct packed {
		mode_t             mode;
		logic signed [W-1:0] bx;
		logic signed [W-1:0] by;
		logic signed [W-1:0] pxd;
		logic signed [W:0]   kxl1;
		logic signed [W:0]   kxh1;
		logic signed [W:0]   kxl2;
		logic signed [W:0]   kxh2;
		logic signed [W:0]   kyl;
		logic signed [W:0]   kyh;
		logic                direct;
	} side_t;

	logic en;

	// stage 1 signals
	logic signed [W-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
	logic signed [W-1:0] mnax, mxax, mnay, mxay, mnbx, mxbx, mnby, mxby;
	logic signed [W:0]   dxa_c, dya_c, dxb_c, dyb_c, x31_c, y31_c, x13_c;
	side_t               side_c;

	logic                vld_s1;
	side_t               side_s1;
	logic signed [W:0]   dxa_s1, dya_s1, dxb_s1, dyb_s1, x31_s1, y31_s1;
	logic signed [W:0]   va_s1, vb_s1, vden_s1;

	logic                vld_s2;
	side_t               side_s2;
	logic signed [PW-1:0] p1_s2, p2_s2, p3_s2, p4_s2, pv_s2;
	logic signed [W:0]   dxa_s2, dya_s2, vden_s2;

	logic                vld_s3;
	side_t               side_s3;
	side_t               side_s3n;
	logic signed [DW-1:0] d_s3, num_s3;
	logic signed [PW-1:0] pv_s3;
	logic signed [W:0]   dxa_s3, dya_s3, vden_s3;

	logic                 vld_s4;
	side_t                side_s4;
	logic signed [PPW-1:0] plx_s4, phx_s4, ply_s4, phy_s4;
	logic signed [DW-1:0] d_s4;
	logic signed [PW-1:0] pv_s4;
	logic signed [W:0]    vden_s4;

	logic                vld_s5;
	side_t               side_s5;
	logic signed [NW-1:0] n1_s5, n2_s5;
	logic signed [DW-1:0] d_s5;
	logic signed [PW-1:0] pv_s5;
	logic signed [W:0]   vden_s5;

	logic signed [NW-1:0] nx_sel, ny_sel;
	logic signed [DW-1:0] den_sel;

	// divider chain, index 0 is the operand register
	logic          vld_d  [0:NW];
	side_t         side_d [0:NW];
	logic          ngx_d  [0:NW];
	logic          ngy_d  [0:NW];
	logic [DW-1:0] den_d  [0:NW];
	logic [DW-1:0] rx_d   [0:NW];
	logic [DW-1:0] ry_d   [0:NW];
	logic [NW-1:0] qx_d   [0:NW];
	logic [NW-1:0] qy_d   [0:NW];

	// output stage
	logic                vld_so;
	logic                hit_so;
	logic signed [W-1:0] cx_so, cy_so;

	logic signed [QS-1:0] qx, qy;
	logic                 fx, fy;
	logic                 hit_c;
	logic signed [W-1:0]  cx_c, cy_c;

	assign en          = !vld_so || results.ready;
	assign pairs.ready = en;

	// clamp quotient magnitude far outside any span, apply sign, floor toward -inf
	function automatic logic signed [QS-1:0] sq(input logic [NW-1:0] qm, input logic neg,
		input logic frac);
		logic                 big;
		logic signed [QS-1:0] qmc;
		big = |qm[NW-1:W+2];
		qmc = big ? (QS'(1) << (W + 2)) : QS'(qm[W+1:0]);
		return neg ? (-qmc - QS'($signed({1'b0, frac}))) : qmc;
	endfunction

	// base + q + frac truncated toward zero, saturated
	function automatic logic signed [W-1:0] tsat(input logic signed [W-1:0] base,
		input logic signed [QS-1:0] q, input logic frac);
		logic signed [QS:0] v;
		v = (QS+1)'(base) + (QS+1)'(q);
		if (v < 0 && frac)
			v = v + (QS+1)'(1);
		if (v > VHI)
			v = VHI;
		if (v < VLO)
			v = VLO;
		return v[W-1:0];
	endfunction

	// strict kl < q + frac < kh
	function automatic logic in_span(input logic signed [QS-1:0] q, input logic frac,
		input logic signed [W:0] kl, input logic signed [W:0] kh);
		logic above;
		above = (q > QS'(kl)) || ((q == QS'(kl)) && frac);
		return above && (q < QS'(kh));
	endfunction

	// stage 1: differences, case split, span bounds relative to the base point
	always_comb begin
		x1 = pairs.a_start_x;
		y1 = pairs.a_start_y;
		x2 = pairs.a_end_x;
		y2 = pairs.a_end_y;
		x3 = pairs.b_start_x;
		y3 = pairs.b_start_y;
		x4 = pairs.b_end_x;
		y4 = pairs.b_end_y;
		dxa_c = (W+1)'(x2) - (W+1)'(x1);
		dya_c = (W+1)'(y2) - (W+1)'(y1);
		dxb_c = (W+1)'(x4) - (W+1)'(x3);
		dyb_c = (W+1)'(y4) - (W+1)'(y3);
		x31_c = (W+1)'(x3) - (W+1)'(x1);
		y31_c = (W+1)'(y3) - (W+1)'(y1);
		x13_c = (W+1)'(x1) - (W+1)'(x3);
		mnax = (x1 < x2) ? x1 : x2;
		mxax = (x1 > x2) ? x1 : x2;
		mnay = (y1 < y2) ? y1 : y2;
		mxay = (y1 > y2) ? y1 : y2;
		mnbx = (x3 < x4) ? x3 : x4;
		mxbx = (x3 > x4) ? x3 : x4;
		mnby = (y3 < y4) ? y3 : y4;
		mxby = (y3 > y4) ? y3 : y4;

		priority if ((dxa_c == 0 && dya_c == 0) || (dxb_c == 0 && dyb_c == 0))
			side_c.mode = MODE_NONE;
		else if (dxa_c != 0 && dxb_c != 0)
			side_c.mode = MODE_GEN;
		else if (dxa_c != 0)
			side_c.mode = MODE_BVERT;
		else if (dxb_c != 0)
			side_c.mode = MODE_AVERT;
		else
			side_c.mode = MODE_NONE;

		side_c.bx   = x1;
		side_c.kxl1 = (W+1)'(mnax) - (W+1)'(x1);
		side_c.kxh1 = (W+1)'(mxax) - (W+1)'(x1);
		side_c.kxl2 = (W+1)'(mnbx) - (W+1)'(x1);
		side_c.kxh2 = (W+1)'(mxbx) - (W+1)'(x1);
		if (side_c.mode == MODE_AVERT) begin
			side_c.by     = y3;
			side_c.pxd    = x1;
			side_c.kyl    = (W+1)'(mnay) - (W+1)'(y3);
			side_c.kyh    = (W+1)'(mxay) - (W+1)'(y3);
			side_c.direct = (x1 > mnbx) && (x1 < mxbx);
		end else begin
			side_c.by     = y1;
			side_c.pxd    = x3;
			side_c.kyl    = (W+1)'(mnby) - (W+1)'(y1);
			side_c.kyh    = (W+1)'(mxby) - (W+1)'(y1);
			side_c.direct = (x3 > mnax) && (x3 < mxax);
		end
	end

	// parallel lines: zero denominator, no line crossing
	always_comb begin
		side_s3n = side_s3;
		if (side_s3.mode == MODE_GEN && d_s3 == 0)
			side_s3n.mode = MODE_NONE;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_d[0] <= 1'b0;
		end else if (en) begin
			vld_s1 <= pairs.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_d[0] <= vld_s5;
		end
	end

	// front stages: differences, products, solve terms, split wide products, divider operands
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_c;
			dxa_s1  <= dxa_c;
			dya_s1  <= dya_c;
			dxb_s1  <= dxb_c;
			dyb_s1  <= dyb_c;
			x31_s1  <= x31_c;
			y31_s1  <= y31_c;
			va_s1   <= (side_c.mode == MODE_AVERT) ? dyb_c : dya_c;
			vb_s1   <= (side_c.mode == MODE_AVERT) ? x13_c : x31_c;
			vden_s1 <= (side_c.mode == MODE_AVERT) ? dxb_c : dxa_c;

			side_s2 <= side_s1;
			p1_s2   <= PW'(dxa_s1) * PW'(dyb_s1);
			p2_s2   <= PW'(dya_s1) * PW'(dxb_s1);
			p3_s2   <= PW'(x31_s1) * PW'(dyb_s1);
			p4_s2   <= PW'(y31_s1) * PW'(dxb_s1);
			pv_s2   <= PW'(va_s1) * PW'(vb_s1);
			dxa_s2  <= dxa_s1;
			dya_s2  <= dya_s1;
			vden_s2 <= vden_s1;

			side_s3 <= side_s2;
			d_s3    <= DW'(p1_s2) - DW'(p2_s2);
			num_s3  <= DW'(p3_s2) - DW'(p4_s2);
			pv_s3   <= pv_s2;
			dxa_s3  <= dxa_s2;
			dya_s3  <= dya_s2;
			vden_s3 <= vden_s2;

			// numerator split into a signed high and an unsigned low slice
			side_s4 <= side_s3n;
			plx_s4  <= PPW'($signed({1'b0, num_s3[LW-1:0]})) * PPW'(dxa_s3);
			phx_s4  <= PPW'($signed(num_s3[DW-1:LW])) * PPW'(dxa_s3);
			ply_s4  <= PPW'($signed({1'b0, num_s3[LW-1:0]})) * PPW'(dya_s3);
			phy_s4  <= PPW'($signed(num_s3[DW-1:LW])) * PPW'(dya_s3);
			d_s4    <= d_s3;
			pv_s4   <= pv_s3;
			vden_s4 <= vden_s3;

			side_s5 <= side_s4;
			n1_s5   <= (NW'(phx_s4) <<< LW) + NW'(plx_s4);
			n2_s5   <= (NW'(phy_s4) <<< LW) + NW'(ply_s4);
			d_s5    <= d_s4;
			pv_s5   <= pv_s4;
			vden_s5 <= vden_s4;

			side_d[0] <= side_s5;
			ngx_d[0]  <= nx_sel[NW-1] ^ den_sel[DW-1];
			ngy_d[0]  <= ny_sel[NW-1] ^ den_sel[DW-1];
			den_d[0]  <= den_sel[DW-1] ? (~den_sel + DW'(1)) : den_sel;
			rx_d[0]   <= '0;
			ry_d[0]   <= '0;
			qx_d[0]   <= nx_sel[NW-1] ? (~nx_sel + NW'(1)) : nx_sel;
			qy_d[0]   <= ny_sel[NW-1] ? (~ny_sel + NW'(1)) : ny_sel;
		end
	end

	// divider operands by case
	always_comb begin
		if (side_s5.mode == MODE_GEN) begin
			nx_sel  = n1_s5;
			ny_sel  = n2_s5;
			den_sel = d_s5;
		end else begin
			nx_sel  = '0;
			ny_sel  = NW'(pv_s5);
			den_sel = DW'(vden_s5);
		end
	end

	// one quotient bit per stage for x and y
	for (genvar k = 0; k < NW; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_d[k+1] <= 1'b0;
			else if (en)
				vld_d[k+1] <= vld_d[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_d[k+1] <= side_d[k];
				ngx_d[k+1]  <= ngx_d[k];
				ngy_d[k+1]  <= ngy_d[k];
				den_d[k+1]  <= den_d[k];
			end
		end

		sgi_div_stage #(.DW(DW), .NW(NW)) u_div_x (
			.clk   (clk),
			.en    (en),
			.den   (den_d[k]),
			.rem_i (rx_d[k]),
			.nq_i  (qx_d[k]),
			.rem_o (rx_d[k+1]),
			.nq_o  (qx_d[k+1])
		);

		sgi_div_stage #(.DW(DW), .NW(NW)) u_div_y (
			.clk   (clk),
			.en    (en),
			.den   (den_d[k]),
			.rem_i (ry_d[k]),
			.nq_i  (qy_d[k]),
			.rem_o (ry_d[k+1]),
			.nq_o  (qy_d[k+1])
		);
	end

	// final stage: floor quotients, truncate and saturate, strict span tests
	always_comb begin
		fx = |rx_d[NW];
		fy = |ry_d[NW];
		qx = sq(qx_d[NW], ngx_d[NW], fx);
		qy = sq(qy_d[NW], ngy_d[NW], fy);
		unique case (side_d[NW].mode)
			MODE_GEN: begin
				cx_c  = tsat(side_d[NW].bx, qx, fx);
				cy_c  = tsat(side_d[NW].by, qy, fy);
				hit_c = in_span(qx, fx, side_d[NW].kxl1, side_d[NW].kxh1) &&
					in_span(qx, fx, side_d[NW].kxl2, side_d[NW].kxh2);
			end
			MODE_BVERT, MODE_AVERT: begin
				cx_c  = side_d[NW].pxd;
				cy_c  = tsat(side_d[NW].by, qy, fy);
				hit_c = side_d[NW].direct &&
					in_span(qy, fy, side_d[NW].kyl, side_d[NW].kyh);
			end
			default: begin
				cx_c  = '0;
				cy_c  = '0;
				hit_c = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_so <= 1'b0;
		else if (en)
			vld_so <= vld_d[NW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_so <= hit_c;
			cx_so  <= cx_c;
			cy_so  <= cy_c;
		end
	end

	assign results.valid   = vld_so;
	assign results.hit     = hit_so;
	assign results.cross_x = cx_so;
	assign results.cross_y = cy_so;

endmodule
